// ----- rtl/olpm_pkg.sv -----
// Shared widths, command codes and control structs for the prefix-max LIS engine.
`timescale 1ns / 1ps
`default_nettype none

package olpm_pkg;

	// Default number of value ranks held in the store
	localparam int unsigned RANKS_DEF = 1024;

	// Fixed payload widths
	localparam int unsigned RANK_W = 11;
	localparam int unsigned LEN_W  = 11;

	// Largest length the store can carry; pushes saturate here
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Command codes
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Work request handed from the top level to the tree unit
	typedef struct packed {
		logic              cmd;
		logic [RANK_W-1:0] value_rank;
	} olpm_req_t;

	// Tree unit status back to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} olpm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/olpm_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface olpm_in_if import olpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [RANK_W-1:0] value_rank;

	modport source (output valid, output cmd, output value_rank, input ready);
	modport sink   (input valid, input cmd, input value_rank, output ready);
endinterface

interface olpm_out_if import olpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] length;

	modport source (output valid, output length, input ready);
	modport sink   (input valid, input length, output ready);
endinterface

`default_nettype wire

// ----- rtl/olpm_tree.sv -----
// Fenwick prefix-max tree in one RAM, walked one node per cycle by a small sequencer.
`timescale 1ns / 1ps
`default_nettype none

module olpm_tree import olpm_pkg::*; #(
	parameter int unsigned RANKS = RANKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  olpm_req_t        req,
	input  logic             ack,
	output olpm_stat_t       stat,
	output logic [LEN_W-1:0] len
);

	// RAM address, tree position (holds up to 2*RANKS) and rank compare widths
	localparam int unsigned AW = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int unsigned PW = AW + 2;
	localparam int unsigned XW = (PW > RANK_W) ? PW : RANK_W;

	localparam logic [XW-1:0] RANKS_X = XW'(RANKS);
	localparam logic [PW-1:0] RANKS_P = PW'(RANKS);
	localparam logic [AW-1:0] CLR_LAST = AW'(RANKS - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_QRY   = 5'b00100,
		S_UPD   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic              rd_vld_q;

	logic              cmd_q;
	logic [PW-1:0]     qpos_q;
	logic [PW-1:0]     upos_q;
	logic [LEN_W-1:0]  acc_q;
	logic [LEN_W-1:0]  len_q;
	logic [AW-1:0]     ra_q;

	logic [LEN_W-1:0]  mem [RANKS];
	logic [LEN_W-1:0]  rd_data_q;

	logic              q_issue;
	logic              u_issue;
	logic              re;
	logic [AW-1:0]     ra;
	logic              we;
	logic [AW-1:0]     wa;
	logic [LEN_W-1:0]  wd;
	logic [PW-1:0]     q_low;
	logic [PW-1:0]     u_low;
	logic [XW-1:0]     rank_x;
	logic [XW-1:0]     q_src;
	logic [PW-1:0]     qpos_start;
	logic [PW-1:0]     upos_start;
	logic [LEN_W-1:0]  acc_max;
	logic [LEN_W-1:0]  acc_inc;

	// Starts: query walks down from the bound, push down from rank-1 and up from its rank
	always_comb begin
		rank_x = XW'(req.value_rank);
		if (req.cmd == CMD_QUERY) begin
			q_src = rank_x;
		end else if (rank_x == '0) begin
			q_src = '0;
		end else begin
			q_src = rank_x - XW'(1);
		end
		qpos_start = (q_src > RANKS_X) ? RANKS_P : q_src[PW-1:0];
		if (rank_x == '0) begin
			upos_start = PW'(1);
		end else if (rank_x > RANKS_X) begin
			upos_start = '0;
		end else begin
			upos_start = rank_x[PW-1:0];
		end
	end

	// Tree walk steps: strip or add the lowest set bit
	assign q_low = qpos_q & (~qpos_q + PW'(1));
	assign u_low = upos_q & (~upos_q + PW'(1));

	// RAM read issue, one node per cycle
	assign q_issue = (state_q == S_QRY) && (qpos_q != '0);
	assign u_issue = (state_q == S_UPD) && (upos_q != '0) && (upos_q <= RANKS_P);
	assign re      = q_issue || u_issue;
	assign ra      = q_issue ? AW'(qpos_q - PW'(1)) : AW'(upos_q - PW'(1));

	// RAM write: zero sweep after reset, else raise the node read last cycle
	always_comb begin
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = '0;
		end else begin
			we = (state_q == S_UPD) && rd_vld_q;
			wa = ra_q;
			wd = (rd_data_q > len_q) ? rd_data_q : len_q;
		end
	end

	assign acc_max = (rd_data_q > acc_q) ? rd_data_q : acc_q;
	assign acc_inc = (acc_q == LEN_MAX) ? LEN_MAX : acc_q + LEN_W'(1);

	// Tree storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= re;
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_QRY;
					end
				end
				S_QRY: begin
					if (!q_issue && !rd_vld_q) begin
						state_q <= (cmd_q == CMD_QUERY) ? S_FIN : S_UPD;
					end
				end
				S_UPD: begin
					if (!u_issue && !rd_vld_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Walk pointers and running maximum
	always_ff @(posedge clk) begin
		if (re) begin
			ra_q <= ra;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q  <= req.cmd;
					qpos_q <= qpos_start;
					upos_q <= upos_start;
					acc_q  <= '0;
				end
			end
			S_QRY: begin
				if (rd_vld_q) begin
					acc_q <= acc_max;
				end
				if (q_issue) begin
					qpos_q <= qpos_q - q_low;
				end
				if (!q_issue && !rd_vld_q) begin
					len_q <= (cmd_q == CMD_QUERY) ? acc_q : acc_inc;
				end
			end
			S_UPD: begin
				if (u_issue) begin
					upos_q <= upos_q + u_low;
				end
			end
			default: ;
		endcase
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_FIN);
	assign len       = len_q;

	// Update walk only climbs, so write-back trails the new read
	assert property (@(posedge clk) disable iff (!arst_n)
		(we && re && state_q == S_UPD) |-> (ra > wa))
		else $error("update walk wrote at or above its next read");

	// No read may still be in flight when the result is posted
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> !rd_vld_q)
		else $error("result posted with a tree read outstanding");

	// Query pointer never leaves the tree
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QRY) |-> (qpos_q <= RANKS_P))
		else $error("query pointer beyond last rank");

	// A push always ends a subsequence of at least one element
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && cmd_q == CMD_PUSH) |-> (len_q != '0))
		else $error("push produced a zero length");

endmodule

`default_nettype wire

// ----- rtl/online_lis_prefix_max_engine.sv -----
// Command beat to result beat: each command walks the tree; a query of bound x walks
// ones(min(x,RANKS)) nodes, a push ones(a-1) nodes down, then the nodes from a up, and the
// result is then posted through the output register.
// Throughput: one command at a time, one RAM node read per cycle; a finished result waits
// in an output register while the next command is taken.
// Reset (arst_n low, asynchronous): the RAM is swept to zero after release, no command beat meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module online_lis_prefix_max_engine import olpm_pkg::*; #(
	parameter int unsigned RANKS = RANKS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	olpm_in_if.sink      item,
	olpm_out_if.source   result
);

	olpm_req_t        req;
	olpm_stat_t       stat;
	logic             start;
	logic             ack;
	logic [LEN_W-1:0] tree_len;
	logic             out_vld_q;
	logic [LEN_W-1:0] out_len_q;

	// Command beat goes straight to the tree unit
	assign req.cmd        = item.cmd;
	assign req.value_rank = item.value_rank;
	assign item.ready     = stat.idle;
	assign start          = item.valid && stat.idle;

	// Output register frees when empty or being drained
	assign ack = !out_vld_q || result.ready;

	olpm_tree #(
		.RANKS (RANKS)
	) u_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.ack    (ack),
		.stat   (stat),
		.len    (tree_len)
	);

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (stat.done && ack) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && ack) begin
			out_len_q <= tree_len;
		end
	end

	assign result.valid  = out_vld_q;
	assign result.length = out_len_q;

endmodule

`default_nettype wire

// ----- verif/online_lis_prefix_max_engine_tb.sv -----
// Self-checking testbench for the online LIS prefix-max engine: driver, monitor and length predictor.
`timescale 1ns / 1ps

module online_lis_prefix_max_engine_tb;
	import olpm_pkg::*;

	localparam int unsigned RANKS       = RANKS_DEF;
	localparam int unsigned SEGMENTS    = 12;
	localparam int unsigned SEG_ITEMS   = 75;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned LIMIT       = 400000;

	// One command waiting to be sent, with the idle rates of its phase
	typedef struct {
		logic              cmd;
		logic [RANK_W-1:0] rank;
		int unsigned       send_pct;
		int unsigned       recv_pct;
		bit                drain;
		bit                hold;
	} lis_cmd_t;

	// One length owed by the block, in command order
	typedef struct {
		logic              cmd;
		logic [RANK_W-1:0] rank;
		logic [LEN_W-1:0]  length;
	} lis_due_t;

	logic clk;
	logic arst_n;

	olpm_in_if  item_ch ();
	olpm_out_if result_ch ();

	online_lis_prefix_max_engine #(.RANKS(RANKS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	lis_cmd_t    cmd_backlog[$];
	lis_due_t    lis_lengths_due[$];
	lis_cmd_t    on_wire;
	logic [LEN_W-1:0] rank_best[1:RANKS];

	int unsigned faults;
	int unsigned cycles;
	int unsigned hold_left;
	bit          hold_go;
	int unsigned recv_pct;
	int unsigned phase_send;
	int unsigned phase_recv;
	int unsigned seg_fill;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		faults++;
	endtask

	// Best length over ranks 1..k; zero for an empty prefix, clamped at the top rank
	function automatic int unsigned best_upto(input int unsigned k);
		if (k == 0)
			return 0;
		return rank_best[(k > RANKS) ? RANKS : k];
	endfunction

	// Apply one command to the local rank table and return the length it yields
	function automatic logic [LEN_W-1:0] lis_advance(input logic c, input logic [RANK_W-1:0] r);
		int unsigned len;
		int unsigned lo;
		if (c == CMD_QUERY)
			return LEN_W'(best_upto(r));
		len = (r == 0) ? 1 : best_upto(r - 1) + 1;
		if (len > LEN_MAX)
			len = LEN_MAX;
		// raise the whole suffix; ranks past the table leave it alone
		lo = (r == 0) ? 1 : r;
		for (int unsigned i = lo; i <= RANKS; i++) begin
			if (rank_best[i] < len)
				rank_best[i] = LEN_W'(len);
		end
		return LEN_W'(len);
	endfunction

	task automatic queue_cmd(input logic c, input logic [RANK_W-1:0] r,
			input bit drain = 1'b0, input bit hold = 1'b0);
		lis_cmd_t entry;
		entry = '{c, r, phase_send, phase_recv, drain, hold};
		cmd_backlog = {cmd_backlog, entry};
		seg_fill++;
	endtask

	// Ranks at the edges: zero, beyond the table, the top rank, the first rank
	function automatic logic [RANK_W-1:0] edge_rank();
		case ($urandom_range(3))
			0: return '0;
			1: return RANK_W'($urandom_range(RANKS + 1, 2047));
			2: return RANK_W'(RANKS);
			default: return RANK_W'(1);
		endcase
	endfunction

	// Driver: offers backlog beats, records the owed length on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid      <= 1'b0;
			item_ch.cmd        <= CMD_PUSH;
			item_ch.value_rank <= '0;
			hold_go            <= 1'b0;
			recv_pct           <= 0;
		end else begin : drive
			bit fire;
			bit take;
			lis_due_t owed;
			fire = item_ch.valid && item_ch.ready;
			take = 1'b0;
			if (fire) begin
				owed = '{on_wire.cmd, on_wire.rank,
					lis_advance(on_wire.cmd, on_wire.rank)};
				lis_lengths_due = {lis_lengths_due, owed};
			end
			hold_go <= fire && on_wire.hold;
			if (!item_ch.valid || fire) begin
				// a draining beat waits until every owed length has come back
				if (cmd_backlog.size() != 0
						&& !(cmd_backlog[0].drain && lis_lengths_due.size() != 0)
						&& $urandom_range(99) >= cmd_backlog[0].send_pct)
					take = 1'b1;
				if (take) begin
					on_wire = cmd_backlog.pop_front();
					item_ch.valid      <= 1'b1;
					item_ch.cmd        <= on_wire.cmd;
					item_ch.value_rank <= on_wire.rank;
					recv_pct           <= on_wire.recv_pct;
				end else begin
					item_ch.valid      <= 1'b0;
					item_ch.cmd        <= 1'($urandom);
					item_ch.value_rank <= RANK_W'($urandom);
				end
			end
		end
	end

	// Long receiver hold-off, started by a marked beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Monitor: checks each result beat against the oldest owed length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin : watch
			lis_due_t want;
			if (result_ch.valid && result_ch.ready) begin
				if (lis_lengths_due.size() == 0) begin
					report_mismatch($sformatf("result beat length=%0d with nothing owed",
						result_ch.length));
				end else begin
					want = lis_lengths_due.pop_front();
					if (result_ch.length !== want.length)
						report_mismatch($sformatf("cmd=%0d rank=%0d length=%0d, want %0d",
							want.cmd, want.rank, result_ch.length, want.length));
				end
			end
			result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned run_len;
		int unsigned style;
		faults = 0;
		cycles = 0;
		arst_n = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.cmd        = CMD_PUSH;
		item_ch.value_rank = '0;
		result_ch.ready    = 1'b0;
		for (int unsigned i = 1; i <= RANKS; i++)
			rank_best[i] = '0;

		// Directed: empty table, rank zero, top rank, ranks past the table, ties
		phase_send = 0;
		phase_recv = 0;
		queue_cmd(CMD_QUERY, RANK_W'(1));
		queue_cmd(CMD_QUERY, '0);
		queue_cmd(CMD_QUERY, RANK_W'(2047));
		queue_cmd(CMD_QUERY, RANK_W'(RANKS));
		queue_cmd(CMD_PUSH,  '0);
		queue_cmd(CMD_QUERY, '0);
		queue_cmd(CMD_QUERY, RANK_W'(1));
		queue_cmd(CMD_PUSH,  RANK_W'(1));
		queue_cmd(CMD_PUSH,  RANK_W'(RANKS));
		queue_cmd(CMD_QUERY, RANK_W'(RANKS));
		queue_cmd(CMD_QUERY, RANK_W'(RANKS - 1));
		queue_cmd(CMD_PUSH,  RANK_W'(RANKS + 1));
		queue_cmd(CMD_QUERY, RANK_W'(2047));
		queue_cmd(CMD_PUSH,  RANK_W'(2047));
		queue_cmd(CMD_PUSH,  RANK_W'(2));
		queue_cmd(CMD_PUSH,  RANK_W'(3));
		queue_cmd(CMD_PUSH,  RANK_W'(3));
		queue_cmd(CMD_QUERY, RANK_W'(3));
		queue_cmd(CMD_PUSH,  RANK_W'(5));
		queue_cmd(CMD_QUERY, RANK_W'(4));
		queue_cmd(CMD_QUERY, RANK_W'(5));
		queue_cmd(CMD_PUSH,  RANK_W'(RANKS - 1));
		queue_cmd(CMD_QUERY, RANK_W'(1280));
		queue_cmd(CMD_PUSH,  RANK_W'(1536));

		// Random segments, rotating through the idle phases
		for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin phase_send = 0;  phase_recv = 0;  end
				1: begin phase_send = 64; phase_recv = 0;  end
				2: begin phase_send = 0;  phase_recv = 64; end
				default: begin phase_send = 25; phase_recv = 25; end
			endcase
			seg_fill = 0;
			// each segment opens once the block has drained; some start a long hold-off
			queue_cmd(CMD_QUERY, RANK_W'($urandom_range(1, RANKS)), 1'b1, (seg % 4) == 0);
			while (seg_fill < SEG_ITEMS) begin
				style = $urandom_range(9);
				if (style < 6) begin
					// increasing run with occasional ties and queries in between
					run_len = $urandom_range(4, 40);
					r = $urandom_range(1, 96);
					for (int unsigned k = 0; k < run_len && seg_fill < SEG_ITEMS; k++) begin
						if ($urandom_range(4) == 0) begin
							queue_cmd(CMD_QUERY, RANK_W'($urandom_range(0, RANKS)));
						end else begin
							queue_cmd(CMD_PUSH, RANK_W'(r));
							r = r + $urandom_range(0, 24);
							if (r > RANKS)
								r = $urandom_range(1, 96);
						end
					end
				end else if (style < 9) begin
					queue_cmd(1'($urandom), RANK_W'($urandom_range(0, 2047)));
				end else begin
					queue_cmd(1'($urandom), edge_rank());
				end
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (lis_lengths_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- online_lis_prefix_max_engine.f -----
rtl/olpm_pkg.sv
rtl/olpm_if.sv
rtl/olpm_tree.sv
rtl/online_lis_prefix_max_engine.sv
verif/online_lis_prefix_max_engine_tb.sv
